// ===== sv/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the timer table
// Request and result codes and the fixed field widths of both channels.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int REQ_BITS      = 2;
  localparam int DEST_BITS     = 8;
  localparam int DURATION_BITS = 31;
  localparam int CANCEL_BITS   = 16;
  localparam int KIND_BITS     = 3;
  localparam int TIMER_ID_BITS = 16;

  typedef logic [REQ_BITS-1:0]  req_type_t;
  typedef logic [KIND_BITS-1:0] result_kind_t;

  // request codes
  localparam req_type_t REQ_TICK      = 2'd0;
  localparam req_type_t REQ_START_ONE = 2'd1;
  localparam req_type_t REQ_START_REP = 2'd2;
  localparam req_type_t REQ_CANCEL    = 2'd3;

  // result codes
  localparam result_kind_t KIND_STARTED   = 3'd0;
  localparam result_kind_t KIND_FULL      = 3'd1;
  localparam result_kind_t KIND_EXPIRED   = 3'd2;
  localparam result_kind_t KIND_CANCELLED = 3'd3;
  localparam result_kind_t KIND_NO_MATCH  = 3'd4;

endpackage

// ===== sv/mts_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_req_if: request channel
// Valid/ready channel that carries one timer request per transfer.
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [mts_pkg::REQ_BITS-1:0]          req_type;
  logic [mts_pkg::DEST_BITS-1:0]         dest_id;
  logic [mts_pkg::DURATION_BITS-1:0]     duration;
  logic [mts_pkg::CANCEL_BITS-1:0]       cancel_id;

  modport source (output valid, req_type, dest_id, duration, cancel_id, input ready);
  modport sink   (input valid, req_type, dest_id, duration, cancel_id, output ready);
endinterface

// ===== sv/mts_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_rsp_if: result channel
// Valid/ready channel that carries one timer result per transfer.
// ----------------------------------------------------------------------------
interface mts_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [mts_pkg::KIND_BITS-1:0]         result_kind;
  logic [mts_pkg::TIMER_ID_BITS-1:0]     timer_id;
  logic [mts_pkg::DEST_BITS-1:0]         dest_out;
  logic                                  last;

  modport source (output valid, result_kind, timer_id, dest_out, last, input ready);
  modport sink   (input valid, result_kind, timer_id, dest_out, last, output ready);
endinterface

// ===== sv/mts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cell: one timer slot of the ring
// Holds one slot and loads its neighbor's slot whenever the ring shifts.
// ----------------------------------------------------------------------------
module mts_cell #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic                           in_valid,
  input  logic [ID_BITS-1:0]             in_ident,
  input  logic [mts_pkg::DEST_BITS-1:0]  in_dest,
  input  logic [TIME_BITS-1:0]           in_deadline,
  input  logic                           in_repeat,
  input  logic [TIME_BITS-1:0]           in_interval,
  output logic                           slot_valid,
  output logic [ID_BITS-1:0]             slot_ident,
  output logic [mts_pkg::DEST_BITS-1:0]  slot_dest,
  output logic [TIME_BITS-1:0]           slot_deadline,
  output logic                           slot_repeat,
  output logic [TIME_BITS-1:0]           slot_interval
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (shift) begin
      slot_valid <= in_valid;
    end
  end

  // payload carries no reset; it is only read behind a valid mark
  always_ff @(posedge clk) begin
    if (shift) begin
      slot_ident    <= in_ident;
      slot_dest     <= in_dest;
      slot_deadline <= in_deadline;
      slot_repeat   <= in_repeat;
      slot_interval <= in_interval;
    end
  end

endmodule

// ===== sv/multi_timer_service.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_service: table of one-shot and repeating timers
// Start, cancel and tick requests against a ring of timer slots.
// ----------------------------------------------------------------------------
// The timer slots sit in a ring of NUM_TIMERS cells that shifts toward cell 0.
// For every request the ring turns once: on each shift the slot in cell 0 is
// examined, updated and fed back into the far end, so slots are visited in
// slot order and the ring is back in place after NUM_TIMERS shifts. A request
// is taken in the idle state, the scan state visits the slots one per shift,
// and the done state closes the request. A start fills the lowest free slot
// met in slot order, as the ring turns, and answers "started" with the
// new id, or "table full". A cancel frees every slot whose id matches and
// answers "cancelled" or "no match" with the requested id. A tick advances
// time by one and answers with one "expired" result per due slot, in slot
// order, or with nothing when no slot is due; a deadline counts as due when
// time minus deadline, modulo 2^TIME_BITS, has its top bit clear. The final
// result of each request has last set. The ring stalls while the result
// register holds a result that has not been taken.
// ----------------------------------------------------------------------------
module multi_timer_service #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 32,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  mts_req_if.sink     req,
  mts_rsp_if.source   rsp
);

  localparam int CNT_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DEST_BITS = mts_pkg::DEST_BITS;
  localparam int TID_BITS  = mts_pkg::TIMER_ID_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state;
  logic [CNT_BITS-1:0]        cnt;

  // request held for the whole ring turn
  mts_pkg::req_type_t         req_kind;
  logic [DEST_BITS-1:0]       dest_q;
  logic [TIME_BITS-1:0]       dur_q;
  logic [ID_BITS-1:0]         cid_q;

  logic [TIME_BITS-1:0]       cur_time;
  logic [ID_BITS-1:0]         next_ident;
  logic                       placed;
  logic                       hit;

  // last expiry seen, held back until it is known whether another follows
  logic                       pend_valid;
  logic [ID_BITS-1:0]         pend_ident;
  logic [DEST_BITS-1:0]       pend_dest;

  // result register
  logic                       o_valid;
  mts_pkg::result_kind_t      o_kind;
  logic [TID_BITS-1:0]        o_id;
  logic [DEST_BITS-1:0]       o_dest;
  logic                       o_last;

  // ring of cells
  logic                       c_valid    [NUM_TIMERS];
  logic [ID_BITS-1:0]         c_ident    [NUM_TIMERS];
  logic [DEST_BITS-1:0]       c_dest     [NUM_TIMERS];
  logic [TIME_BITS-1:0]       c_deadline [NUM_TIMERS];
  logic                       c_repeat   [NUM_TIMERS];
  logic [TIME_BITS-1:0]       c_interval [NUM_TIMERS];

  // head slot after update, fed into the far end
  logic                       tail_valid;
  logic [ID_BITS-1:0]         tail_ident;
  logic [DEST_BITS-1:0]       tail_dest;
  logic [TIME_BITS-1:0]       tail_deadline;
  logic                       tail_repeat;
  logic [TIME_BITS-1:0]       tail_interval;

  logic                       can_load;
  logic                       shift;
  logic                       fire;
  logic                       hit_now;
  logic                       place_now;
  logic [TIME_BITS-1:0]       diff;

  // width adapters for fields whose width follows a parameter
  logic [TIME_BITS+mts_pkg::DURATION_BITS-1:0] dur_ext;
  logic [ID_BITS+mts_pkg::CANCEL_BITS-1:0]     cid_ext;
  logic [ID_BITS+TID_BITS-1:0]                 pend_id_ext;
  logic [ID_BITS+TID_BITS-1:0]                 next_id_ext;
  logic [ID_BITS+TID_BITS-1:0]                 cid_out_ext;

  assign dur_ext     = {{TIME_BITS{1'b0}}, req.duration};
  assign cid_ext     = {{ID_BITS{1'b0}}, req.cancel_id};
  assign pend_id_ext = {{TID_BITS{1'b0}}, pend_ident};
  assign next_id_ext = {{TID_BITS{1'b0}}, next_ident};
  assign cid_out_ext = {{TID_BITS{1'b0}}, cid_q};

  assign can_load = !o_valid || rsp.ready;
  assign shift    = (state == ST_SCAN) && can_load;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = o_valid;
  assign rsp.result_kind = o_kind;
  assign rsp.timer_id    = o_id;
  assign rsp.dest_out    = o_dest;
  assign rsp.last        = o_last;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      if (gi == NUM_TIMERS - 1) begin : g_end
        mts_cell #(
          .TIME_BITS (TIME_BITS),
          .ID_BITS   (ID_BITS)
        ) u_cell (
          .clk           (clk),
          .rst           (rst),
          .shift         (shift),
          .in_valid      (tail_valid),
          .in_ident      (tail_ident),
          .in_dest       (tail_dest),
          .in_deadline   (tail_deadline),
          .in_repeat     (tail_repeat),
          .in_interval   (tail_interval),
          .slot_valid    (c_valid[gi]),
          .slot_ident    (c_ident[gi]),
          .slot_dest     (c_dest[gi]),
          .slot_deadline (c_deadline[gi]),
          .slot_repeat   (c_repeat[gi]),
          .slot_interval (c_interval[gi])
        );
      end else begin : g_mid
        mts_cell #(
          .TIME_BITS (TIME_BITS),
          .ID_BITS   (ID_BITS)
        ) u_cell (
          .clk           (clk),
          .rst           (rst),
          .shift         (shift),
          .in_valid      (c_valid[gi+1]),
          .in_ident      (c_ident[gi+1]),
          .in_dest       (c_dest[gi+1]),
          .in_deadline   (c_deadline[gi+1]),
          .in_repeat     (c_repeat[gi+1]),
          .in_interval   (c_interval[gi+1]),
          .slot_valid    (c_valid[gi]),
          .slot_ident    (c_ident[gi]),
          .slot_dest     (c_dest[gi]),
          .slot_deadline (c_deadline[gi]),
          .slot_repeat   (c_repeat[gi]),
          .slot_interval (c_interval[gi])
        );
      end
    end
  endgenerate

  // Update the head slot on its way round the ring.
  always_comb begin
    tail_valid    = c_valid[0];
    tail_ident    = c_ident[0];
    tail_dest     = c_dest[0];
    tail_deadline = c_deadline[0];
    tail_repeat   = c_repeat[0];
    tail_interval = c_interval[0];
    fire          = 1'b0;
    hit_now       = 1'b0;
    place_now     = 1'b0;
    diff          = cur_time - c_deadline[0];
    case (req_kind)
      mts_pkg::REQ_TICK: begin
        // due when the wrapped distance past the deadline is non-negative
        if (c_valid[0] && !diff[TIME_BITS-1]) begin
          fire = 1'b1;
          if (c_repeat[0]) begin
            tail_deadline = c_deadline[0] + c_interval[0];
          end else begin
            tail_valid = 1'b0;
          end
        end
      end
      mts_pkg::REQ_START_ONE, mts_pkg::REQ_START_REP: begin
        // take the first free slot met in slot order
        if (!placed && !c_valid[0]) begin
          place_now     = 1'b1;
          tail_valid    = 1'b1;
          tail_ident    = next_ident;
          tail_dest     = dest_q;
          tail_deadline = cur_time + dur_q;
          tail_repeat   = (req_kind == mts_pkg::REQ_START_REP);
          tail_interval = dur_q;
        end
      end
      mts_pkg::REQ_CANCEL: begin
        if (c_valid[0] && (c_ident[0] == cid_q)) begin
          hit_now    = 1'b1;
          tail_valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      cur_time   <= '0;
      next_ident <= '0;
      placed     <= 1'b0;
      hit        <= 1'b0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            // a tick moves time before the slots are compared
            if (req.req_type == mts_pkg::REQ_TICK) begin
              cur_time <= cur_time + 1'b1;
            end
            cnt        <= '0;
            placed     <= 1'b0;
            hit        <= 1'b0;
            pend_valid <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (can_load) begin
            if (place_now) begin
              placed <= 1'b1;
            end
            if (hit_now) begin
              hit <= 1'b1;
            end
            if (fire) begin
              // the held expiry is now known not to be the final one
              if (pend_valid) begin
                o_valid <= 1'b1;
              end
              pend_valid <= 1'b1;
            end
            if (cnt == CNT_BITS'(NUM_TIMERS - 1)) begin
              state <= ST_DONE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (can_load) begin
            case (req_kind)
              mts_pkg::REQ_TICK: begin
                if (pend_valid) begin
                  o_valid <= 1'b1;
                end
              end
              mts_pkg::REQ_START_ONE, mts_pkg::REQ_START_REP: begin
                o_valid <= 1'b1;
                if (placed) begin
                  next_ident <= next_ident + 1'b1;
                end
              end
              default: begin
                o_valid <= 1'b1;
              end
            endcase
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request payload and result payload.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req.valid) begin
      req_kind <= req.req_type;
      dest_q   <= req.dest_id;
      dur_q    <= dur_ext[TIME_BITS-1:0];
      cid_q    <= cid_ext[ID_BITS-1:0];
    end
    if (shift && fire) begin
      pend_ident <= c_ident[0];
      pend_dest  <= c_dest[0];
      o_kind     <= mts_pkg::KIND_EXPIRED;
      o_id       <= pend_id_ext[TID_BITS-1:0];
      o_dest     <= pend_dest;
      o_last     <= 1'b0;
    end
    if ((state == ST_DONE) && can_load) begin
      o_last <= 1'b1;
      case (req_kind)
        mts_pkg::REQ_TICK: begin
          o_kind <= mts_pkg::KIND_EXPIRED;
          o_id   <= pend_id_ext[TID_BITS-1:0];
          o_dest <= pend_dest;
        end
        mts_pkg::REQ_START_ONE, mts_pkg::REQ_START_REP: begin
          o_kind <= placed ? mts_pkg::KIND_STARTED : mts_pkg::KIND_FULL;
          o_id   <= placed ? next_id_ext[TID_BITS-1:0] : '0;
          o_dest <= '0;
        end
        default: begin
          o_kind <= hit ? mts_pkg::KIND_CANCELLED : mts_pkg::KIND_NO_MATCH;
          o_id   <= cid_out_ext[TID_BITS-1:0];
          o_dest <= '0;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the timer table
// Sends tick, start and cancel requests with random pacing on both channels.
// A scoreboard keeps its own copy of the timer slots, the time and the next
// id, predicts the results of every accepted request and compares each
// returned result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  import mts_pkg::*;

  localparam int NUM_TIMERS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = 16;
  localparam int MAX_GAP     = 12;
  localparam int LONG_HOLD   = 400;
  // one full ring turn per request, with room for a burst of results behind it
  localparam int TAIL_CYCLES = 3 * (NUM_TIMERS + 2);
  localparam int DRAIN_LIMIT = 50000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    req_type_t                op;
    logic [DEST_BITS-1:0]     dest;
    logic [DURATION_BITS-1:0] duration;
    logic [CANCEL_BITS-1:0]   cancel_id;
  } timer_request_t;

  typedef struct packed {
    result_kind_t             kind;
    logic [TIMER_ID_BITS-1:0] timer_id;
    logic [DEST_BITS-1:0]     dest_out;
    logic                     last;
  } timer_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow timer table plus the queue of results still owed
  // --------------------------------------------------------------------------
  class timer_result_scoreboard;
    bit                 live     [NUM_TIMERS];
    bit [ID_BITS-1:0]   ident    [NUM_TIMERS];
    bit [DEST_BITS-1:0] dest     [NUM_TIMERS];
    bit [TIME_BITS-1:0] deadline [NUM_TIMERS];
    bit                 rep      [NUM_TIMERS];
    bit [TIME_BITS-1:0] interval [NUM_TIMERS];
    bit [TIME_BITS-1:0] now_ticks;
    bit [ID_BITS-1:0]   id_next;
    timer_result_t      pending_results[$];
    int                 errors;

    task report(string msg);
      // keep the log short when the block is badly broken
      if (errors < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function timer_result_t make_result(result_kind_t kind, bit [ID_BITS-1:0] id,
                                        bit [DEST_BITS-1:0] d);
      timer_result_t res;
      res.kind     = kind;
      res.timer_id = id;
      res.dest_out = d;
      res.last     = 1'b0;
      return res;
    endfunction

    // pick one id of a running timer, or -1 when the table is empty
    function int random_live_id();
      int ids[$];
      for (int s = 0; s < NUM_TIMERS; s++) if (live[s]) ids = {ids, int'(ident[s])};
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // advance the shadow table by one accepted request and queue its results
    function void note_request(timer_request_t r);
      timer_result_t      burst[$];
      bit [TIME_BITS-1:0] age;
      int                 slot;
      bit                 hit;
      case (r.op)
        REQ_TICK: begin
          now_ticks++;
          for (int s = 0; s < NUM_TIMERS; s++) begin
            age = now_ticks - deadline[s];
            if (live[s] && !age[TIME_BITS-1]) begin
              burst = {burst, make_result(KIND_EXPIRED, ident[s], dest[s])};
              if (rep[s]) deadline[s] += interval[s];
              else live[s] = 1'b0;
            end
          end
        end
        REQ_START_ONE, REQ_START_REP: begin
          slot = -1;
          for (int s = NUM_TIMERS - 1; s >= 0; s--) if (!live[s]) slot = s;
          if (slot < 0) begin
            burst = {burst, make_result(KIND_FULL, '0, '0)};
          end else begin
            live[slot]     = 1'b1;
            ident[slot]    = id_next;
            dest[slot]     = r.dest;
            deadline[slot] = now_ticks + TIME_BITS'(r.duration);
            rep[slot]      = (r.op == REQ_START_REP);
            interval[slot] = TIME_BITS'(r.duration);
            burst = {burst, make_result(KIND_STARTED, id_next, '0)};
            id_next++;
          end
        end
        default: begin
          hit = 1'b0;
          for (int s = 0; s < NUM_TIMERS; s++) begin
            if (live[s] && ident[s] == r.cancel_id) begin
              live[s] = 1'b0;
              hit     = 1'b1;
            end
          end
          burst = {burst, make_result(hit ? KIND_CANCELLED : KIND_NO_MATCH,
                                      r.cancel_id, '0)};
        end
      endcase
      if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[k]) pending_results = {pending_results, burst[k]};
    endfunction

    task check_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d id %0h dest %0h last %0b",
                         got.kind, got.timer_id, got.dest_out, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
      if (got.timer_id !== want.timer_id)
        report($sformatf("timer_id %0h, expected %0h (kind %0d)",
                         got.timer_id, want.timer_id, want.kind));
      if (got.dest_out !== want.dest_out)
        report($sformatf("dest_out %0h, expected %0h (id %0h)",
                         got.dest_out, want.dest_out, want.timer_id));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b (id %0h)",
                         got.last, want.last, want.timer_id));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  mts_req_if req_ch();
  mts_rsp_if rsp_ch();

  multi_timer_service #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  timer_result_scoreboard sb = new();

  // pacing controls for the request driver and the result taker
  bit req_pacing       = 1'b1;
  bit rsp_pacing       = 1'b1;
  bit req_burst        = 1'b0;
  bit rsp_burst        = 1'b0;
  bit hold_off_request = 1'b0;

  function automatic timer_request_t make_request(req_type_t op, logic [DEST_BITS-1:0] d,
                                                  logic [DURATION_BITS-1:0] dur,
                                                  logic [CANCEL_BITS-1:0] cid);
    timer_request_t r;
    r.op        = op;
    r.dest      = d;
    r.duration  = dur;
    r.cancel_id = cid;
    return r;
  endfunction

  // Offer one request and hold it until the block takes it. Valid stays high
  // after the transfer so back-to-back requests follow without a gap; drop it
  // only when a gap is drawn.
  task automatic send_request(timer_request_t r);
    int gap;
    gap = 0;
    if (req_pacing) begin
      // flip between paced and back-to-back stretches now and then
      if ($urandom_range(0, 19) == 0) req_burst = !req_burst;
      if (!req_burst) gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= r.op;
    req_ch.dest_id   <= r.dest;
    req_ch.duration  <= r.duration;
    req_ch.cancel_id <= r.cancel_id;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
  endtask

  // Random traffic: mostly ticks and starts with short durations so timers
  // really expire, cancels aimed at running timers, and a tail of noise.
  task automatic random_requests(int count, bit with_hold);
    timer_request_t r;
    int             pick;
    int             live_id;
    for (int k = 0; k < count; k++) begin
      // fill every field with random content, then shape the ones that matter
      r.dest      = DEST_BITS'($urandom);
      r.duration  = DURATION_BITS'($urandom);
      r.cancel_id = CANCEL_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.op = REQ_TICK;
      end else if (pick < 78) begin
        r.op = (pick < 60) ? REQ_START_ONE : REQ_START_REP;
        pick = $urandom_range(0, 99);
        if (pick < 70) r.duration = DURATION_BITS'($urandom_range(0, 6));
        else if (pick < 85) r.duration = DURATION_BITS'($urandom_range(0, 40));
        // else keep the full-width duration: far deadlines, near the half range
      end else begin
        r.op = REQ_CANCEL;
        live_id = sb.random_live_id();
        if (live_id >= 0 && $urandom_range(0, 4) != 0) r.cancel_id = CANCEL_BITS'(live_id);
      end
      // ask the taker for a long stall; keep sending so the block backs up
      if (with_hold && k == count / 3) hold_off_request = 1'b1;
      send_request(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result taker: draw a stall per result, take it, hand it to the scoreboard
  // --------------------------------------------------------------------------
  initial begin
    timer_result_t got;
    int            gap;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = 0;
      if (hold_off_request) begin
        gap = LONG_HOLD;
        hold_off_request = 1'b0;
      end else if (rsp_pacing) begin
        if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
        if (!rsp_burst) gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got.kind     = rsp_ch.result_kind;
      got.timer_id = rsp_ch.timer_id;
      got.dest_out = rsp_ch.dest_out;
      got.last     = rsp_ch.last;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int live_id;
    int drain;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.dest_id   <= '0;
    req_ch.duration  <= '0;
    req_ch.cancel_id <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening.
    // A cancel with nothing running must still answer "no match".
    send_request(make_request(REQ_CANCEL, 8'h00, 31'd0, 16'hFFFF));
    // A tick with nothing due answers with nothing at all.
    send_request(make_request(REQ_TICK, 8'hFF, 31'h7FFF_FFFF, 16'h0000));
    // Zero duration: both fire on the next tick; the one-shot is freed, the
    // repeating one with zero interval keeps firing on every tick.
    send_request(make_request(REQ_START_ONE, 8'hFF, 31'd0, 16'h0000));
    send_request(make_request(REQ_START_REP, 8'h00, 31'd0, 16'hFFFF));
    send_request(make_request(REQ_TICK, 8'h00, 31'd0, 16'h0000));
    // Longest duration: deadline just short of half the time range away.
    send_request(make_request(REQ_START_REP, 8'hA5, 31'h7FFF_FFFF, 16'h0000));
    send_request(make_request(REQ_START_ONE, 8'h5A, 31'd2, 16'h0000));
    // Cancel the zero-interval repeater, then again: second one finds nothing.
    send_request(make_request(REQ_CANCEL, 8'h00, 31'd0, 16'd1));
    send_request(make_request(REQ_CANCEL, 8'hFF, 31'h7FFF_FFFF, 16'd1));
    // Fill the table, then one more start hits the table-full answer.
    for (int k = 0; k < NUM_TIMERS - 2; k++)
      send_request(make_request(k[0] ? REQ_START_REP : REQ_START_ONE, DEST_BITS'($urandom),
                                DURATION_BITS'($urandom_range(0, 3)),
                                CANCEL_BITS'($urandom)));
    send_request(make_request(REQ_START_ONE, 8'h77, 31'd5, 16'h0000));
    send_request(make_request(REQ_TICK, 8'h00, 31'd0, 16'h0000));
    send_request(make_request(REQ_TICK, 8'h00, 31'd0, 16'h0000));
    // id 0 expired long ago; the longest-duration timer is still there.
    send_request(make_request(REQ_CANCEL, 8'h00, 31'd0, 16'd0));
    send_request(make_request(REQ_CANCEL, 8'h00, 31'd0, 16'd2));

    // First random stretch, with one long stall on the result side.
    random_requests(40, 1'b1);

    // Clear the table with back-to-back cancels of every running timer.
    req_pacing = 1'b0;
    rsp_pacing = 1'b0;
    live_id = sb.random_live_id();
    while (live_id >= 0) begin
      send_request(make_request(REQ_CANCEL, 8'h00, 31'd0, CANCEL_BITS'(live_id)));
      live_id = sb.random_live_id();
    end
    req_pacing = 1'b1;
    rsp_pacing = 1'b1;

    // Second random stretch from an empty table.
    random_requests(40, 1'b0);
    req_ch.valid <= 1'b0;

    // Wait for every owed result, then a tail for anything unasked-for.
    drain = 0;
    while (sb.pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: calls the run hung once the delay below runs out; a full run
  // with the worst stalls ends well before it.
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mts_pkg.sv
sv/mts_req_if.sv
sv/mts_rsp_if.sv
sv/mts_cell.sv
sv/multi_timer_service.sv
sim/tb.sv
